FILE: hw/rtl/fomap_pkg.sv
`timescale 1ns / 1ps
package fomap_pkg;
    localparam int MaxExtents = 8;
    localparam int MaxStrips  = 16;
    localparam int ExtW   = $clog2(MaxExtents);
    localparam int StripW = $clog2(MaxStrips);
    localparam int StripAddrW = ExtW + StripW;

    localparam logic [1:0] MODE_MAP    = 2'd0;
    localparam logic [1:0] MODE_SIMPLE = 2'd1;
    localparam logic [1:0] MODE_HEADER = 2'd2;
    localparam logic [1:0] MODE_STRIP  = 2'd3;

    localparam logic [1:0] ST_MAPPED = 2'd0;
    localparam logic [1:0] ST_ERROR  = 2'd1;
    localparam logic [1:0] ST_WRITE  = 2'd2;

    localparam logic [1:0] REG_KIND  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_FSIZE = 2'd2;

    // divider request and reply
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [63:0] remainder;
    } div_rsp_t;
endpackage

FILE: hw/rtl/fomap_divider.sv
`timescale 1ns / 1ps
module fomap_divider
    import fomap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    // restoring divider, one quotient bit a cycle
    logic [63:0] quot_reg, quot_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[63]};
        diff      = shifted - {1'b0, dsr_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = 64'd0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_next  = diff[63:0];
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[63:0];
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;
endmodule

FILE: hw/rtl/file_offset_extent_mapper_core.sv
`timescale 1ns / 1ps
// Maps a file offset through an eight-entry extent table, simple or striped.
// A table write item is written at accept and then passes through S_OUT to
// the output register. A map request walks one extent per cycle (up to eight)
// in S_WALK. A simple hit or a miss then goes through S_OUT. A striped hit
// runs two passes of a shared bit-serial divider (offset by chunk, then
// chunk number by strip count), each with its hand-off. It then uses one
// shared 32x32 multiplier in S_MUL and S_MUL2 (low and high half of the
// stripe number times the chunk), a strip table read and the hand-off to the
// output register. in_stall is high until the result has moved into the
// output register. No clearing pass; tables hold undefined values until
// written.
module file_offset_extent_mapper_core
    import fomap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [2:0]  ext_slot,
    input  logic [3:0]  strip_slot,
    input  logic [63:0] dev_offset,
    input  logic [63:0] ext_bytes,
    input  logic [7:0]  dev_number,
    input  logic [31:0] chunk_bytes,
    input  logic [4:0]  strip_total,
    input  logic [63:0] req_offset,
    input  logic [63:0] request_length,
    input  logic [15:0] request_flags,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] dev_addr,
    output logic [63:0] map_offset,
    output logic [63:0] map_length,
    output logic [7:0]  dev_index_out,
    output logic [15:0] flags_out
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_DIV1  = 3'd2;
    localparam logic [2:0] S_DIV2  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_MUL2  = 3'd7;

    // configuration registers
    logic        kind_reg;
    logic [3:0]  count_reg;
    logic [63:0] fsize_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= 1'b0;
            count_reg <= 4'd0;
            fsize_reg <= 64'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                REG_KIND:  kind_reg  <= pwdata[0];
                REG_COUNT: count_reg <= pwdata[3:0];
                REG_FSIZE: fsize_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_KIND:  prdata = {63'd0, kind_reg};
            REG_COUNT: prdata = {60'd0, count_reg};
            REG_FSIZE: prdata = fsize_reg;
            default:   prdata = 64'd0;
        endcase
    end

    // extent tables (small, read at the walk index)
    logic [63:0] ext_ofs_mem   [MaxExtents];
    logic [63:0] ext_len_mem   [MaxExtents];
    logic [7:0]  ext_dev_mem   [MaxExtents];
    logic [31:0] ext_chunk_mem [MaxExtents];
    logic [4:0]  ext_ns_mem    [MaxExtents];
    // strip memory, registered read
    logic [63:0] strip_ofs_mem [MaxExtents*MaxStrips];
    logic [7:0]  strip_dev_mem [MaxExtents*MaxStrips];

    logic [2:0]  state_reg, state_next;
    logic [ExtW-1:0] idx_reg, idx_next;
    logic [63:0] local_reg, local_next;
    logic [63:0] fofs_reg, fofs_next;
    logic [63:0] rlen_reg, rlen_next;
    logic [15:0] flags_reg, flags_next;
    logic [63:0] cofs_reg, cofs_next;
    logic [63:0] cnum_reg, cnum_next;
    logic [63:0] prod_reg, prod_next;
    logic [StripW-1:0] strip_reg, strip_next;
    logic [63:0] sofs_rd_reg;
    logic [7:0]  sdev_rd_reg;
    logic        ov_reg, ov_next;
    logic [1:0]  st_reg, st_next;
    logic [63:0] addr_reg, addr_next;
    logic [63:0] mofs_reg, mofs_next;
    logic [63:0] mlen_reg, mlen_next;
    logic [7:0]  mdev_reg, mdev_next;
    logic [15:0] mflg_reg, mflg_next;

    div_req_t dreq;
    div_rsp_t drsp;

    fomap_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic        accept;
    logic        wr_simple, wr_header, wr_strip;
    logic [3:0]  count_eff;
    logic [63:0] e_len, e_size, chunk64, rem_len;
    logic [4:0]  e_ns;
    logic        last_ext;
    logic [31:0] mul_a;
    logic [63:0] mul_p;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign wr_simple = accept && mode == MODE_SIMPLE;
    assign wr_header = accept && mode == MODE_HEADER;
    assign wr_strip  = accept && mode == MODE_STRIP;
    assign count_eff = (count_reg > 4'(MaxExtents)) ? 4'(MaxExtents) : count_reg;
    assign e_len     = ext_len_mem[idx_reg];
    assign e_size    = (e_len < fsize_reg) ? e_len : fsize_reg;
    assign e_ns      = ext_ns_mem[idx_reg];
    assign chunk64   = {32'd0, ext_chunk_mem[idx_reg]};
    assign last_ext  = ({1'b0, idx_reg} + 4'd1) >= count_eff;
    assign rem_len   = chunk64 - cofs_reg;

    // shared 32x32 multiplier, low half of the stripe number first
    assign mul_a = (state_reg == S_MUL2) ? cnum_reg[63:32] : cnum_reg[31:0];
    assign mul_p = {32'd0, mul_a} * chunk64;

    // table writes
    always_ff @(posedge clk)
    begin
        if (wr_simple)
        begin
            ext_ofs_mem[ext_slot] <= dev_offset;
            ext_len_mem[ext_slot] <= ext_bytes;
            ext_dev_mem[ext_slot] <= dev_number;
        end
        if (wr_header)
        begin
            ext_len_mem[ext_slot]   <= ext_bytes;
            ext_chunk_mem[ext_slot] <= chunk_bytes;
            ext_ns_mem[ext_slot]    <= strip_total;
        end
        if (wr_strip)
        begin
            strip_ofs_mem[{ext_slot, strip_slot}] <= dev_offset;
            strip_dev_mem[{ext_slot, strip_slot}] <= dev_number;
        end
        sofs_rd_reg <= strip_ofs_mem[{idx_reg, strip_reg}];
        sdev_rd_reg <= strip_dev_mem[{idx_reg, strip_reg}];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        local_next = local_reg;
        fofs_next  = fofs_reg;
        rlen_next  = rlen_reg;
        flags_next = flags_reg;
        cofs_next  = cofs_reg;
        cnum_next  = cnum_reg;
        prod_next  = prod_reg;
        strip_next = strip_reg;
        ov_next    = ov_reg;
        st_next    = st_reg;
        addr_next  = addr_reg;
        mofs_next  = mofs_reg;
        mlen_next  = mlen_reg;
        mdev_next  = mdev_reg;
        mflg_next  = mflg_reg;
        dreq.start    = 1'b0;
        dreq.dividend = local_reg;
        dreq.divisor  = chunk64;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next   = (mode == MODE_MAP) ? ST_ERROR : ST_WRITE;
                    addr_next = 64'd0;
                    mofs_next = 64'd0;
                    mlen_next = 64'd0;
                    mdev_next = 8'd0;
                    mflg_next = 16'd0;
                    if (mode == MODE_MAP)
                    begin
                        idx_next   = '0;
                        local_next = req_offset;
                        fofs_next  = req_offset;
                        rlen_next  = request_length;
                        flags_next = request_flags;
                        state_next = (count_eff == 4'd0) ? S_OUT : S_WALK;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_WALK:
            begin
                if (!kind_reg)
                begin
                    if (local_reg < e_len)
                    begin
                        st_next    = ST_MAPPED;
                        addr_next  = ext_ofs_mem[idx_reg] + local_reg;
                        mofs_next  = fofs_reg;
                        mlen_next  = (rlen_reg < e_len - local_reg) ? rlen_reg
                                                                   : e_len - local_reg;
                        mdev_next  = ext_dev_mem[idx_reg];
                        mflg_next  = flags_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        local_next = local_reg - e_len;
                        idx_next   = idx_reg + 1'b1;
                        if (last_ext)
                            state_next = S_OUT;
                    end
                end
                else if (e_size == 64'd0)
                    state_next = S_OUT;
                else if (local_reg < e_size)
                begin
                    if (chunk64 == 64'd0 || e_ns == 5'd0)
                        state_next = S_OUT;
                    else
                    begin
                        dreq.start = 1'b1;
                        state_next = S_DIV1;
                    end
                end
                else
                begin
                    local_next = local_reg - e_size;
                    idx_next   = idx_reg + 1'b1;
                    if (last_ext)
                        state_next = S_OUT;
                end
            end
            S_DIV1:
            begin
                if (drsp.done)
                begin
                    cofs_next     = drsp.remainder;
                    dreq.start    = 1'b1;
                    dreq.dividend = drsp.quotient;
                    dreq.divisor  = {59'd0, e_ns};
                    state_next    = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (drsp.done)
                begin
                    cnum_next = drsp.quotient;
                    strip_next = drsp.remainder[StripW-1:0];
                    if (drsp.remainder >= 64'(MaxStrips))
                        state_next = S_OUT;
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // low half of the stripe number times chunk
                prod_next  = mul_p;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                // high half adds into the upper word, low 64 bits kept
                prod_next  = prod_reg + {mul_p[31:0], 32'd0};
                state_next = S_READ;
            end
            S_READ:
            begin
                st_next    = ST_MAPPED;
                addr_next  = sofs_rd_reg + cofs_reg + prod_reg;
                mofs_next  = fofs_reg;
                mlen_next  = (rlen_reg < rem_len) ? rlen_reg : rem_len;
                mdev_next  = sdev_rd_reg;
                mflg_next  = flags_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        local_reg <= local_next;
        fofs_reg  <= fofs_next;
        rlen_reg  <= rlen_next;
        flags_reg <= flags_next;
        cofs_reg  <= cofs_next;
        cnum_reg  <= cnum_next;
        prod_reg  <= prod_next;
        strip_reg <= strip_next;
        st_reg    <= st_next;
        addr_reg  <= addr_next;
        mofs_reg  <= mofs_next;
        mlen_reg  <= mlen_next;
        mdev_reg  <= mdev_next;
        mflg_reg  <= mflg_next;
    end

    // output register loads when the item leaves the sequencer
    logic [1:0]  o_st_reg;
    logic [63:0] o_addr_reg, o_ofs_reg, o_len_reg;
    logic [7:0]  o_dev_reg;
    logic [15:0] o_flg_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ov_reg || !out_stall))
        begin
            o_st_reg   <= st_reg;
            o_addr_reg <= addr_reg;
            o_ofs_reg  <= mofs_reg;
            o_len_reg  <= mlen_reg;
            o_dev_reg  <= mdev_reg;
            o_flg_reg  <= mflg_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign status        = o_st_reg;
    assign dev_addr      = o_addr_reg;
    assign map_offset    = o_ofs_reg;
    assign map_length    = o_len_reg;
    assign dev_index_out = o_dev_reg;
    assign flags_out     = o_flg_reg;
endmodule

FILE: bench/tb_file_offset_extent_mapper_core.sv
`timescale 1ns / 1ps
module tb_file_offset_extent_mapper_core;
    import fomap_pkg::*;

    typedef struct {
        logic [1:0]  mode;
        logic [2:0]  ext_slot;
        logic [3:0]  strip_slot;
        logic [63:0] dev_offset;
        logic [63:0] ext_bytes;
        logic [7:0]  dev_number;
        logic [31:0] chunk_bytes;
        logic [4:0]  strip_total;
        logic [63:0] req_offset;
        logic [63:0] request_length;
        logic [15:0] request_flags;
    } map_item_t;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] dev_addr;
        logic [63:0] map_offset;
        logic [63:0] map_length;
        logic [7:0]  dev_num;
        logic [15:0] flags;
    } map_result_t;

    // extent table mirror and expected mappings
    class extent_map_scoreboard;
        logic        kind;
        logic [3:0]  ext_count;
        logic [63:0] fsize;
        logic [63:0] ext_base [MaxExtents];
        logic [63:0] ext_len [MaxExtents];
        logic [7:0]  ext_dev [MaxExtents];
        logic [31:0] ext_chunk [MaxExtents];
        logic [4:0]  ext_strips [MaxExtents];
        logic [63:0] strip_base [MaxExtents * MaxStrips];
        logic [7:0]  strip_dev [MaxExtents * MaxStrips];
        map_result_t pending_maps [$];
        int          mismatches;

        function new();
            kind = 0;
            ext_count = 0;
            fsize = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] value);
            if (idx == REG_KIND)
                kind = value[0];
            else if (idx == REG_COUNT)
                ext_count = value[3:0];
            else if (idx == REG_FSIZE)
                fsize = value;
        endfunction

        function map_result_t translate(map_item_t it);
            map_result_t r;
            logic [63:0] local_ofs, size, chunk, ns, cnum, cofs, stripe, strip;
            int          n, k;
            r = '{ST_ERROR, 0, 0, 0, 0, 0};
            if (it.mode != MODE_MAP) begin
                r.status = ST_WRITE;
                if (it.mode == MODE_SIMPLE) begin
                    ext_base[it.ext_slot] = it.dev_offset;
                    ext_len[it.ext_slot] = it.ext_bytes;
                    ext_dev[it.ext_slot] = it.dev_number;
                end else if (it.mode == MODE_HEADER) begin
                    ext_len[it.ext_slot] = it.ext_bytes;
                    ext_chunk[it.ext_slot] = it.chunk_bytes;
                    ext_strips[it.ext_slot] = it.strip_total;
                end else begin
                    k = it.ext_slot * MaxStrips + it.strip_slot;
                    strip_base[k] = it.dev_offset;
                    strip_dev[k] = it.dev_number;
                end
                return r;
            end
            n = (ext_count > MaxExtents) ? MaxExtents : ext_count;
            local_ofs = it.req_offset;
            for (int i = 0; i < n; i++) begin
                if (!kind) begin
                    if (local_ofs < ext_len[i]) begin
                        r.status = ST_MAPPED;
                        r.dev_addr = ext_base[i] + local_ofs;
                        r.map_offset = it.req_offset;
                        r.map_length = (it.request_length < ext_len[i] - local_ofs)
                            ? it.request_length : ext_len[i] - local_ofs;
                        r.dev_num = ext_dev[i];
                        r.flags = it.request_flags;
                        return r;
                    end
                    local_ofs -= ext_len[i];
                end else begin
                    size = (ext_len[i] < fsize) ? ext_len[i] : fsize;
                    chunk = ext_chunk[i];
                    ns = ext_strips[i];
                    // zero-size extent stops the walk
                    if (size == 0)
                        return r;
                    if (local_ofs < size) begin
                        if (chunk == 0 || ns == 0)
                            return r;
                        cnum = local_ofs / chunk;
                        cofs = local_ofs % chunk;
                        stripe = cnum / ns;
                        strip = cnum % ns;
                        if (strip >= MaxStrips)
                            return r;
                        k = i * MaxStrips + int'(strip);
                        r.status = ST_MAPPED;
                        r.dev_addr = strip_base[k] + cofs + stripe * chunk;
                        r.map_offset = it.req_offset;
                        r.map_length = (it.request_length < chunk - cofs)
                            ? it.request_length : chunk - cofs;
                        r.dev_num = strip_dev[k];
                        r.flags = it.request_flags;
                        return r;
                    end
                    local_ofs -= size;
                end
            end
            return r;
        endfunction

        function void note_item(map_item_t it);
            pending_maps.push_back(translate(it));
        endfunction

        function void check_result(map_result_t got);
            map_result_t want;
            if (pending_maps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status %0d addr %h", got.status,
                        got.dev_addr);
                return;
            end
            want = pending_maps.pop_front();
            if (got.status !== want.status || got.dev_addr !== want.dev_addr ||
                got.map_offset !== want.map_offset ||
                got.map_length !== want.map_length ||
                got.dev_num !== want.dev_num || got.flags !== want.flags) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp st %0d addr %h ofs %h len %h dev %h flg %h",
                        want.status, want.dev_addr, want.map_offset, want.map_length,
                        want.dev_num, want.flags);
                    $display("         got st %0d addr %h ofs %h len %h dev %h flg %h",
                        got.status, got.dev_addr, got.map_offset, got.map_length,
                        got.dev_num, got.flags);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [2:0]  ext_slot;
    logic [3:0]  strip_slot;
    logic [63:0] dev_offset;
    logic [63:0] ext_bytes;
    logic [7:0]  dev_number;
    logic [31:0] chunk_bytes;
    logic [4:0]  strip_total;
    logic [63:0] req_offset;
    logic [63:0] request_length;
    logic [15:0] request_flags;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [63:0] dev_addr;
    logic [63:0] map_offset;
    logic [63:0] map_length;
    logic [7:0]  dev_index_out;
    logic [15:0] flags_out;

    extent_map_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int quiet_cycles;

    file_offset_extent_mapper_core DUT (.*);

    initial clk = 0;
    always #1 clk = ~clk;

    // result side: stalls and checking
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{status, dev_addr, map_offset, map_length,
                dev_index_out, flags_out});
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("file_offset_extent_mapper_core regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_len();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return 64'($urandom_range(4096, 1));
        else if (sel < 80)
            return 64'd0;
        else if (sel < 90)
            return 64'hffff_ffff_ffff_0000 | 64'($urandom_range(65535));
        return rand64();
    endfunction

    function automatic map_item_t rand_item();
        map_item_t it;
        int sel;
        sel = $urandom_range(99);
        it.mode = (sel < 50) ? MODE_MAP : (sel < 68) ? MODE_SIMPLE :
            (sel < 82) ? MODE_HEADER : MODE_STRIP;
        it.ext_slot = 3'($urandom);
        it.strip_slot = 4'($urandom);
        it.dev_offset = rand64();
        it.ext_bytes = rand_len();
        it.dev_number = 8'($urandom);
        sel = $urandom_range(99);
        it.chunk_bytes = (sel < 80) ? $urandom_range(512, 1) :
            (sel < 88) ? 32'd0 : $urandom;
        it.strip_total = ($urandom_range(9) == 0) ? 5'd0 : 5'($urandom_range(16, 1));
        sel = $urandom_range(99);
        it.req_offset = (sel < 75) ? 64'($urandom_range(30000)) :
            (sel < 85) ? 64'd0 : rand64();
        it.request_length = ($urandom_range(1) == 0) ? 64'($urandom_range(8192)) :
            rand64();
        it.request_flags = 16'($urandom);
        return it;
    endfunction

    task automatic send_item(map_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= it.mode;
        ext_slot <= it.ext_slot;
        strip_slot <= it.strip_slot;
        dev_offset <= it.dev_offset;
        ext_bytes <= it.ext_bytes;
        dev_number <= it.dev_number;
        chunk_bytes <= it.chunk_bytes;
        strip_total <= it.strip_total;
        req_offset <= it.req_offset;
        request_length <= it.request_length;
        request_flags <= it.request_flags;
        do @(posedge clk); while (in_stall);
        sb.note_item(it);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_maps.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic kind, logic [3:0] cnt, logic [63:0] fs);
        reg_write(REG_KIND, {63'd0, kind});
        reg_write(REG_COUNT, {60'd0, cnt});
        reg_write(REG_FSIZE, fs);
    endtask

    task automatic send_map(logic [63:0] ofs, logic [63:0] len, logic [15:0] flg);
        map_item_t it;
        it = rand_item();
        it.mode = MODE_MAP;
        it.req_offset = ofs;
        it.request_length = len;
        it.request_flags = flg;
        send_item(it);
    endtask

    task automatic send_header(logic [2:0] slot, logic [63:0] bytes,
                               logic [31:0] chunk, logic [4:0] strips);
        map_item_t it;
        it = rand_item();
        it.mode = MODE_HEADER;
        it.ext_slot = slot;
        it.ext_bytes = bytes;
        it.chunk_bytes = chunk;
        it.strip_total = strips;
        send_item(it);
    endtask

    task automatic run_random(int n);
        repeat (n) send_item(rand_item());
    endtask

    initial
    begin
        map_item_t it;
        sb = new();
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_valid = 0;
        out_stall = 0;
        mode = MODE_MAP;
        ext_slot = 0;
        strip_slot = 0;
        dev_offset = 0;
        ext_bytes = 0;
        dev_number = 0;
        chunk_bytes = 0;
        strip_total = 0;
        req_offset = 0;
        request_length = 0;
        request_flags = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // load every table entry so no map reads an unwritten one
        for (int s = 0; s < MaxExtents; s++)
        begin
            it = rand_item();
            it.mode = MODE_SIMPLE;
            it.ext_slot = 3'(s);
            send_item(it);
            it = rand_item();
            it.mode = MODE_HEADER;
            it.ext_slot = 3'(s);
            it.chunk_bytes = $urandom_range(512, 1);
            it.strip_total = 5'($urandom_range(16, 1));
            it.ext_bytes = 64'($urandom_range(4096, 1));
            send_item(it);
            for (int p = 0; p < MaxStrips; p++)
            begin
                it = rand_item();
                it.mode = MODE_STRIP;
                it.ext_slot = 3'(s);
                it.strip_slot = 4'(p);
                send_item(it);
            end
        end
        drain();

        // directed: simple extents, field extremes
        configure(1'b0, 4'd8, 64'd0);
        send_map(64'd0, 64'd0, 16'h0000);
        send_map(64'd0, '1, 16'hffff);
        send_map('1, '1, 16'h5a5a);
        send_map(64'd100, 64'd1, 16'ha5a5);
        drain();

        // directed: striped extents with zero size, zero chunk, zero strips, wide chunk
        configure(1'b1, 4'd15, '1);
        send_header(3'd0, 64'd0, 32'd64, 5'd4);
        send_map(64'd0, 64'd10, 16'h0001);
        send_header(3'd0, 64'd4096, 32'd0, 5'd4);
        send_map(64'd5, 64'd10, 16'h0002);
        send_header(3'd0, 64'd4096, 32'd64, 5'd0);
        send_map(64'd5, 64'd10, 16'h0004);
        send_header(3'd0, 64'd4096, 32'hffff_ffff, 5'd16);
        send_map(64'd4095, '1, 16'h0008);
        send_header(3'd0, '1, 32'd16, 5'd16);
        send_map(64'd1000, 64'd3, 16'h8000);
        send_map(64'hffff_ffff_ffff_fff0, 64'd3, 16'h8000);
        drain();

        // random, no idling
        configure(1'b0, 4'd8, rand64());
        run_random(200);
        drain();

        // striped, idle sender, then a pause until all results are back
        configure(1'b1, 4'd8, '1);
        send_idle_pct = 74;
        run_random(100);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_maps.size() != 0)
            @(posedge clk);
        run_random(100);
        drain();

        // striped with a capped file size, stalling receiver and a long hold
        configure(1'b1, 4'd15, 64'd5000);
        send_idle_pct = 0;
        recv_stall_pct = 74;
        run_random(100);
        hold_cycles = 1500;
        run_random(120);
        drain();

        // no extents at all
        configure(1'b0, 4'd0, 64'd0);
        send_idle_pct = 13;
        recv_stall_pct = 13;
        run_random(60);
        drain();

        // every striped extent empty through file size zero
        configure(1'b1, 4'd3, 64'd0);
        run_random(60);
        drain();

        // mixed tail
        configure(1'b0, 4'd5, rand64());
        run_random(130);
        drain();
        configure(1'b1, 4'd8, 64'd20000);
        run_random(130);
        drain();

        if (sb.mismatches == 0 && sb.pending_maps.size() == 0)
            $display("file_offset_extent_mapper_core regression: pass");
        else
            $display("file_offset_extent_mapper_core regression: fail");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/fomap_pkg.sv
hw/rtl/fomap_divider.sv
hw/rtl/file_offset_extent_mapper_core.sv
bench/tb_file_offset_extent_mapper_core.sv
